@@ hw/rtl/mm_ss_clock_serial_display_unit_assert.svh @@
// Assertion macros for the MM:SS clock display unit.
// Expects signals named clock and reset in the including scope.
`ifndef MM_SS_CLOCK_SERIAL_DISPLAY_UNIT_ASSERT_SVH
`define MM_SS_CLOCK_SERIAL_DISPLAY_UNIT_ASSERT_SVH

// Condition holds at every edge outside reset.
`define MMSS_ASSERT_ALWAYS(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("assertion failed");

// Antecedent at one edge implies consequent at the next.
`define MMSS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ hw/rtl/mmss_pkg.sv @@
// Shared types, codes and the seven-segment table for the MM:SS display unit.
// No dependencies.
package mmss_pkg;

   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_BUTTON = 2'd1;
   localparam logic [1:0] OP_FRAME  = 2'd2;

   localparam logic [1:0] REG_BASE_DIVIDER    = 2'd0;
   localparam logic [1:0] REG_SPEED_THRESHOLD = 2'd1;

   localparam logic [7:0] BASE_DIVIDER_RST    = 8'd92;
   localparam logic [7:0] SPEED_THRESHOLD_RST = 8'd80;
   localparam logic [7:0] COUNTDOWN_RST       = 8'd20;

   // Frame: start bit, four 8-bit codes, three trailing zeros.
   localparam logic [5:0] FRAME_LAST_POS = 6'd35;
   localparam logic [5:0] FRAME_TAIL_POS = 6'd32;

   typedef struct packed {
      logic [2:0] min_tens;
      logic [3:0] min_units;
      logic [2:0] sec_tens;
      logic [3:0] sec_units;
   } time_digits_type;

   typedef struct packed {
      logic       busy;
      logic [5:0] pos;
   } frame_status_type;

   // Segment code of one display position, with blanking and colon.
   function automatic logic [7:0] digit_code(input logic [1:0] pos, input logic [3:0] digit);
      logic [7:0] code;
      case (digit)
         4'd0:    code = 8'hFC;
         4'd1:    code = 8'h60;
         4'd2:    code = 8'hDA;
         4'd3:    code = 8'hF2;
         4'd4:    code = 8'h66;
         4'd5:    code = 8'hB6;
         4'd6:    code = 8'hBE;
         4'd7:    code = 8'hE4;
         4'd8:    code = 8'hFE;
         4'd9:    code = 8'hF6;
         default: code = 8'h00;
      endcase
      if ((pos == 2'd0 || pos == 2'd2) && digit == 4'd0) begin
         code = 8'h00;
      end
      if (pos == 2'd1) begin
         code = code | 8'h01;
      end
      return code;
   endfunction

endpackage

@@ hw/rtl/mmss_time_core.sv @@
// Time keeping: BCD digits, tick countdown, reload and button toggle.
// Uses mmss_pkg.
module mmss_time_core
   import mmss_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            tick,
   input  logic            sample,
   input  logic            button_level,
   input  logic            csr_wr_en,
   input  logic [1:0]      csr_index,
   input  logic [7:0]      csr_wdata,
   output time_digits_type digits
);

   time_digits_type digits_ff, digits_in;
   logic [7:0] countdown_ff, countdown_in;
   logic [7:0] reload_ff, reload_in;
   logic [7:0] threshold_ff, threshold_in;
   logic       held_ff, held_in;
   logic [7:0] cd_dec;

   assign cd_dec = countdown_ff - 8'd1;

   always_comb begin
      digits_in    = digits_ff;
      countdown_in = countdown_ff;
      reload_in    = reload_ff;
      threshold_in = threshold_ff;
      held_in      = held_ff;

      if (tick) begin
         countdown_in = cd_dec;
         if (cd_dec == 8'd0) begin
            countdown_in = reload_ff;
            // carry chain through the four digits
            if (digits_ff.sec_units != 4'd9) begin
               digits_in.sec_units = digits_ff.sec_units + 4'd1;
            end else begin
               digits_in.sec_units = 4'd0;
               if (digits_ff.sec_tens != 3'd5) begin
                  digits_in.sec_tens = digits_ff.sec_tens + 3'd1;
               end else begin
                  digits_in.sec_tens = 3'd0;
                  if (digits_ff.min_units != 4'd9) begin
                     digits_in.min_units = digits_ff.min_units + 4'd1;
                  end else begin
                     digits_in.min_units = 4'd0;
                     if (digits_ff.min_tens != 3'd5) begin
                        digits_in.min_tens = digits_ff.min_tens + 3'd1;
                     end else begin
                        digits_in.min_tens = 3'd0;
                     end
                  end
               end
            end
         end
      end

      if (sample) begin
         if (!button_level && !held_ff) begin
            held_in = 1'b1;
         end else if (button_level && held_ff) begin
            held_in = 1'b0;
            if (reload_ff > threshold_ff) begin
               reload_in = {1'b0, reload_ff[7:1]};
            end else if (reload_ff < threshold_ff) begin
               reload_in = reload_ff[7] ? 8'hFF : {reload_ff[6:0], 1'b0};
            end
         end
      end

      if (csr_wr_en) begin
         case (csr_index)
            REG_BASE_DIVIDER:    reload_in    = csr_wdata;
            REG_SPEED_THRESHOLD: threshold_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digits_ff    <= '{min_tens: 3'd1, min_units: 4'd1, sec_tens: 3'd1, sec_units: 4'd1};
         countdown_ff <= COUNTDOWN_RST;
         reload_ff    <= BASE_DIVIDER_RST;
         threshold_ff <= SPEED_THRESHOLD_RST;
         held_ff      <= 1'b0;
      end else begin
         digits_ff    <= digits_in;
         countdown_ff <= countdown_in;
         reload_ff    <= reload_in;
         threshold_ff <= threshold_in;
         held_ff      <= held_in;
      end
   end

   assign digits = digits_ff;

endmodule

@@ hw/rtl/mmss_frame_shifter.sv @@
// Frame serialiser: 8-bit code shift register reloaded per digit, one bit a cycle unless out_ready stalls.
// Uses mmss_pkg.
module mmss_frame_shifter
   import mmss_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  time_digits_type  digits,
   input  logic             out_ready,
   output logic             out_valid,
   output logic             out_bit,
   output logic             out_last,
   output frame_status_type status
);

   logic       busy_ff, busy_in;
   logic [5:0] pos_ff, pos_in;
   logic [7:0] sr_ff, sr_in;
   logic       valid_ff, valid_in;
   logic       bit_ff, bit_in;
   logic       last_ff, last_in;
   logic       step;
   logic [3:0] sel_digit;

   assign step = busy_ff && (!valid_ff || out_ready);

   always_comb begin
      case (pos_ff[4:3])
         2'd0:    sel_digit = {1'b0, digits.min_tens};
         2'd1:    sel_digit = digits.min_units;
         2'd2:    sel_digit = {1'b0, digits.sec_tens};
         default: sel_digit = digits.sec_units;
      endcase
   end

   always_comb begin
      busy_in  = busy_ff;
      pos_in   = pos_ff;
      sr_in    = sr_ff;
      valid_in = valid_ff && !out_ready;
      bit_in   = bit_ff;
      last_in  = last_ff;

      if (step) begin
         valid_in = 1'b1;
         bit_in   = (pos_ff == 6'd0) ? 1'b1 : sr_ff[7];
         last_in  = (pos_ff == FRAME_LAST_POS);
         // on a digit boundary load the next code, past the last digit zeros
         if (pos_ff[2:0] == 3'd0) begin
            sr_in = (pos_ff == FRAME_TAIL_POS) ? 8'h00 : digit_code(pos_ff[4:3], sel_digit);
         end else begin
            sr_in = {sr_ff[6:0], 1'b0};
         end
         if (pos_ff == FRAME_LAST_POS) begin
            busy_in = 1'b0;
            pos_in  = 6'd0;
         end else begin
            pos_in  = pos_ff + 6'd1;
         end
      end

      if (start) begin
         busy_in = 1'b1;
         pos_in  = 6'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         pos_ff   <= 6'd0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         pos_ff   <= pos_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sr_ff   <= sr_in;
      bit_ff  <= bit_in;
      last_ff <= last_in;
   end

   assign out_valid   = valid_ff;
   assign out_bit     = bit_ff;
   assign out_last    = last_ff;
   assign status.busy = busy_ff;
   assign status.pos  = pos_ff;

endmodule

@@ hw/rtl/mm_ss_clock_serial_display_unit.sv @@
// MM:SS clock with serial seven-segment frame output. Ticks and button samples
// are accepted back to back. A frame request emits 36 transfers, one bit per
// cycle from the 8-bit code shift register unless the result side stalls, so
// it holds the request side while serialising; the next request is taken as
// soon as the last bit sits in the output register.
// Depends on mmss_pkg, mmss_time_core, mmss_frame_shifter and the assert header.
`include "mm_ss_clock_serial_display_unit_assert.svh"

module mm_ss_clock_serial_display_unit
   import mmss_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_op,
   input  logic       req_button_level,
   // result channel
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_serial_bit,
   output logic       rsp_last,
   // register writes, idle only
   input  logic       csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   time_digits_type  digits;
   frame_status_type frame_status;
   logic             req_xfer;
   logic             is_tick;
   logic             is_button;
   logic             is_frame;
   logic             digits_legal;

   // Requests are blocked only while a frame is being serialised; the time
   // cannot change then, so the shifter reads the live digits.
   assign req_ready = !frame_status.busy;
   assign req_xfer  = req_valid && req_ready;

   // Unused op code falls through: accepted, no effect, no transfers.
   assign is_tick   = req_xfer && (req_op == OP_TICK);
   assign is_button = req_xfer && (req_op == OP_BUTTON);
   assign is_frame  = req_xfer && (req_op == OP_FRAME);

   mmss_time_core u_time (
      .clock        (clock),
      .reset        (reset),
      .tick         (is_tick),
      .sample       (is_button),
      .button_level (req_button_level),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .digits       (digits)
   );

   // Output register inside the shifter parts the two sides.
   mmss_frame_shifter u_frame (
      .clock     (clock),
      .reset     (reset),
      .start     (is_frame),
      .digits    (digits),
      .out_ready (rsp_ready),
      .out_valid (rsp_valid),
      .out_bit   (rsp_serial_bit),
      .out_last  (rsp_last),
      .status    (frame_status)
   );

   // Every digit stays within its BCD range.
   assign digits_legal = (digits.sec_units <= 4'd9) && (digits.sec_tens <= 3'd5) &&
                         (digits.min_units <= 4'd9) && (digits.min_tens <= 3'd5);

   `MMSS_ASSERT_NEXT(a_frame_starts, is_frame, frame_status.busy && frame_status.pos == 6'd0)
   `MMSS_ASSERT_ALWAYS(a_idle_pos_zero, frame_status.busy || frame_status.pos == 6'd0)
   `MMSS_ASSERT_ALWAYS(a_digits_legal, digits_legal)

endmodule

@@ tb/tb_mm_ss_clock_serial_display_unit.sv @@
// Self-checking testbench for the MM:SS clock serial display unit: a scoreboard
// class predicts every frame bit, plain tasks drive requests and register writes.
// Depends on mmss_pkg and the mm_ss_clock_serial_display_unit RTL.
module tb_mm_ss_clock_serial_display_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import mmss_pkg::*;

   // Codes the package leaves unnamed: the spare op and the spare register slots.
   localparam logic [1:0] OP_UNUSED    = 2'd3;
   localparam logic [1:0] REG_UNUSED_2 = 2'd2;
   localparam logic [1:0] REG_UNUSED_3 = 2'd3;

   localparam int unsigned SETTLE_CYCLES  = 8;    // frame ends registered
   localparam int unsigned TAIL_CYCLES    = 40;
   localparam int unsigned WATCHDOG_LIMIT = 2000; // cycles without any transfer

   // ------------------------------------------------------------------------
   // Scoreboard: own copy of the clock, divider and button state; queue of
   // expected frame bits as {serial_bit, last}.
   // ------------------------------------------------------------------------
   class mmss_frame_scoreboard;
      logic [7:0]      base_divider;
      logic [7:0]      speed_threshold;
      logic [7:0]      countdown;
      logic [7:0]      reload;
      time_digits_type shown_time;
      bit              button_held;
      logic [1:0]      frame_bits [$];
      int unsigned     fail_count;

      function new();
         fail_count           = 0;
         base_divider         = BASE_DIVIDER_RST;
         speed_threshold      = SPEED_THRESHOLD_RST;
         countdown            = COUNTDOWN_RST;
         reload               = BASE_DIVIDER_RST;
         button_held          = 1'b0;
         shown_time.min_tens  = 3'd1;
         shown_time.min_units = 4'd1;
         shown_time.sec_tens  = 3'd1;
         shown_time.sec_units = 4'd1;
      endfunction

      function void write_reg(input logic [1:0] idx, input logic [7:0] value);
         case (idx)
            REG_BASE_DIVIDER: begin
               base_divider = value;
               reload       = value;
            end
            REG_SPEED_THRESHOLD: begin
               speed_threshold = value;
            end
            default: begin
            end
         endcase
      endfunction

      function void advance_second();
         if (shown_time.sec_units != 4'd9) begin
            shown_time.sec_units = shown_time.sec_units + 4'd1;
         end else begin
            shown_time.sec_units = 4'd0;
            if (shown_time.sec_tens != 3'd5) begin
               shown_time.sec_tens = shown_time.sec_tens + 3'd1;
            end else begin
               shown_time.sec_tens = 3'd0;
               if (shown_time.min_units != 4'd9) begin
                  shown_time.min_units = shown_time.min_units + 4'd1;
               end else begin
                  shown_time.min_units = 4'd0;
                  if (shown_time.min_tens != 3'd5) begin
                     shown_time.min_tens = shown_time.min_tens + 3'd1;
                  end else begin
                     shown_time.min_tens = 3'd0;
                  end
               end
            end
         end
      endfunction

      function void toggle_speed();
         logic [8:0] doubled;
         doubled = {reload, 1'b0};
         if (reload > speed_threshold) begin
            reload = reload >> 1;
         end else if (reload < speed_threshold) begin
            reload = doubled[8] ? 8'hFF : doubled[7:0];
         end
      endfunction

      function logic [7:0] glyph(input logic [3:0] digit);
         case (digit)
            4'd0:    return 8'hFC;
            4'd1:    return 8'h60;
            4'd2:    return 8'hDA;
            4'd3:    return 8'hF2;
            4'd4:    return 8'h66;
            4'd5:    return 8'hB6;
            4'd6:    return 8'hBE;
            4'd7:    return 8'hE4;
            4'd8:    return 8'hFE;
            4'd9:    return 8'hF6;
            default: return 8'h00;
         endcase
      endfunction

      // Start bit, four codes MSB first (tens blanked on zero, colon on
      // minute units), three trailing zeros with last on the final one.
      function void queue_frame();
         logic [3:0] digits [4];
         logic [7:0] code;
         int         p;
         int         b;
         digits[0] = {1'b0, shown_time.min_tens};
         digits[1] = shown_time.min_units;
         digits[2] = {1'b0, shown_time.sec_tens};
         digits[3] = shown_time.sec_units;
         frame_bits.push_back(2'b10);
         for (p = 0; p < 4; p++) begin
            code = glyph(digits[p]);
            if ((p == 0 || p == 2) && digits[p] == 4'd0) begin
               code = 8'h00;
            end
            if (p == 1) begin
               code[0] = 1'b1;
            end
            for (b = 7; b >= 0; b--) begin
               frame_bits.push_back({code[b], 1'b0});
            end
         end
         frame_bits.push_back(2'b00);
         frame_bits.push_back(2'b00);
         frame_bits.push_back(2'b01);
      endfunction

      function void note_request(input logic [1:0] op, input logic level);
         case (op)
            OP_TICK: begin
               countdown = countdown - 8'd1;
               if (countdown == 8'd0) begin
                  countdown = reload;
                  advance_second();
               end
            end
            OP_BUTTON: begin
               if (!level && !button_held) begin
                  button_held = 1'b1;
               end else if (level && button_held) begin
                  button_held = 1'b0;
                  toggle_speed();
               end
            end
            OP_FRAME: begin
               queue_frame();
            end
            default: begin
            end
         endcase
      endfunction

      function void check_result(input logic serial_bit, input logic last_flag);
         logic [1:0] want;
         if (frame_bits.size() == 0) begin
            $display("%0t: unexpected frame bit, serial_bit=%0b last=%0b",
                     $time, serial_bit, last_flag);
            fail_count++;
            return;
         end
         want = frame_bits.pop_front();
         if (serial_bit !== want[1]) begin
            $display("%0t: serial_bit mismatch, expected %0b, actual %0b",
                     $time, want[1], serial_bit);
            fail_count++;
         end
         if (last_flag !== want[0]) begin
            $display("%0t: last mismatch, expected %0b, actual %0b",
                     $time, want[0], last_flag);
            fail_count++;
         end
      endfunction

      function int unsigned pending();
         return frame_bits.size();
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // Clock, DUT and driven signals
   // ------------------------------------------------------------------------
   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [1:0] req_op;
   logic       req_button_level;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_serial_bit;
   logic       rsp_last;
   logic       csr_wr_en;
   logic [1:0] csr_index;
   logic [7:0] csr_wdata;

   mmss_frame_scoreboard frame_board;
   bit                   calm_tail;     // last stretch: no idling on either side
   int unsigned          stall_left;
   int unsigned          quiet_cycles;

   always #5ns clock = ~clock;

   mm_ss_clock_serial_display_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_button_level (req_button_level),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_serial_bit   (rsp_serial_bit),
      .rsp_last         (rsp_last),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // Result side: check each transfer, then pick ready for the next cycle.
   // Stalls come in bursts; none in the calm tail.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         frame_board.check_result(rsp_serial_bit, rsp_last);
      end
      if (reset || calm_tail) begin
         rsp_ready  <= 1'b1;
         stall_left = 0;
      end else if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left = stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left = $urandom_range(0, 7);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Watchdog: any transfer on either side resets the count.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Request side tasks. A request task returns in the step of its transfer
   // with valid possibly still high, so whatever follows must either drive a
   // new request or lower valid in that same step.
   // ------------------------------------------------------------------------
   task automatic sender_gap();
      if (!calm_tail && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic send_req(input logic [1:0] op, input logic level);
      req_valid        <= 1'b1;
      req_op           <= op;
      req_button_level <= level;
      do @(posedge clock); while (!req_ready);
      frame_board.note_request(op, level);
      sender_gap();
   endtask

   // Press then release: toggles the tick speed once, unless reload equals the threshold.
   task automatic press_release();
      send_req(OP_BUTTON, 1'b0);
      send_req(OP_BUTTON, 1'b1);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (frame_board.pending() != 0) @(posedge clock);
   endtask

   // Leaves csr_wr_en high; the caller lowers it after its last write.
   task automatic write_csr(input logic [1:0] idx, input logic [7:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      frame_board.write_reg(idx, value);
   endtask

   task automatic apply_config(input logic [7:0] base, input logic [7:0] thresh);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_csr(REG_BASE_DIVIDER, base);
      write_csr(REG_SPEED_THRESHOLD, thresh);
      csr_wr_en <= 1'b0;
   endtask

   // Long tick run with the odd frame, to walk the clock through its wraps.
   task automatic run_tick_sweep(input int unsigned count);
      int unsigned k;
      for (k = 0; k < count; k++) begin
         if ($urandom_range(0, 39) == 0) begin
            send_req(OP_FRAME, 1'($urandom_range(0, 1)));
         end else begin
            send_req(OP_TICK, 1'($urandom_range(0, 1)));
         end
      end
   endtask

   // Mixed traffic. Button samples mostly follow press/release order so the
   // speed toggles often; one in five is a random level.
   task automatic run_mixed(input int unsigned count, input bit hold_off);
      int unsigned k;
      int unsigned pick;
      logic        level;
      for (k = 0; k < count; k++) begin
         if (hold_off && k == count / 2) begin
            wait_drained();
         end
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            send_req(OP_TICK, 1'($urandom_range(0, 1)));
         end else if (pick < 75) begin
            if ($urandom_range(0, 4) == 0) begin
               level = 1'($urandom_range(0, 1));
            end else begin
               level = frame_board.button_held;
            end
            send_req(OP_BUTTON, level);
         end else if (pick < 95) begin
            send_req(OP_FRAME, 1'($urandom_range(0, 1)));
         end else begin
            send_req(OP_UNUSED, 1'($urandom_range(0, 1)));
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      frame_board      = new();
      calm_tail        = 1'b0;
      stall_left       = 0;
      quiet_cycles     = 0;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_op           <= OP_TICK;
      req_button_level <= 1'b0;
      csr_wr_en        <= 1'b0;
      csr_index        <= REG_BASE_DIVIDER;
      csr_wdata        <= 8'd0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset values: 11:11 frame, stray release, double press, toggle
      // (92 above 80 halves to 46), spare op, then the first second.
      send_req(OP_FRAME, 1'b0);
      send_req(OP_BUTTON, 1'b1);
      send_req(OP_BUTTON, 1'b0);
      send_req(OP_BUTTON, 1'b0);
      send_req(OP_BUTTON, 1'b1);
      send_req(OP_UNUSED, 1'b0);
      send_req(OP_UNUSED, 1'b1);
      send_req(OP_TICK, 1'b1);
      repeat (19) send_req(OP_TICK, 1'b0);
      send_req(OP_FRAME, 1'b1);

      // One second per tick once the running countdown expires: through the
      // seconds wrap, the minute carry and the blanked second tens.
      apply_config(8'd1, 8'd128);
      run_tick_sweep(120);
      send_req(OP_FRAME, 1'b0);

      // Spare register slots, then a reload of 1 halved to 0: the countdown
      // then wraps to 255 instead of advancing; reload equal to threshold.
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_csr(REG_UNUSED_2, 8'($urandom_range(0, 255)));
      write_csr(REG_UNUSED_3, 8'hFF);
      write_csr(REG_BASE_DIVIDER, 8'd1);
      write_csr(REG_SPEED_THRESHOLD, 8'd0);
      csr_wr_en <= 1'b0;
      press_release();
      repeat (20) send_req(OP_TICK, 1'b0);
      send_req(OP_FRAME, 1'b0);
      press_release();
      send_req(OP_FRAME, 1'b0);

      // Doubling saturates at 255, which then equals the threshold.
      apply_config(8'd200, 8'd255);
      press_release();
      press_release();
      send_req(OP_FRAME, 1'b0);

      // Random traffic under several settings, extremes included.
      apply_config(8'd255, 8'd0);
      run_mixed(30, 1'b0);
      apply_config(8'd1, 8'd255);
      run_mixed(30, 1'b1);
      apply_config(8'd7, 8'd7);
      run_mixed(30, 1'b0);
      apply_config(8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)));
      run_mixed(30, 1'b0);
      apply_config(8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)));
      run_mixed(30, 1'b0);

      // Back-to-back tail: requests with no gaps, result side always ready.
      calm_tail = 1'b1;
      run_mixed(40, 1'b0);
      send_req(OP_FRAME, 1'b0);

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (frame_board.fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
